/* sv/smm_pkg.sv */
// smm_pkg: shared constants, types and state codes for the matrix multiplier
// no dependencies
`default_nettype none
package smm_pkg;
	localparam int MaxOrder = 8;
	localparam int ElemBits = 16;
	localparam int InBits = 16;
	localparam int AccBits = 32;
	localparam int IdxBits = 3;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_CLEAR,
		ST_FETCH,
		ST_MUL,
		ST_ACC,
		ST_EMIT
	} state_t;

	// control from sequencer to the product unit
	typedef struct packed {
		logic       start;
		logic [2:0] prod;
	} mul_ctl_t;
endpackage
`default_nettype wire

/* sv/smm_if.sv */
// smm_if: valid/ready channel interfaces for input items, results and config
// depends on smm_pkg
`default_nettype none
interface smm_in_if #(parameter int W = smm_pkg::InBits);
	logic valid;
	logic ready;
	logic signed [W-1:0] a_value;
	logic signed [W-1:0] b_value;
	modport source(output valid, a_value, b_value, input ready);
	modport sink(input valid, a_value, b_value, output ready);
endinterface

interface smm_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] c_value;
	logic [2:0] row;
	logic [2:0] col;
	logic last;
	modport source(output valid, c_value, row, col, last, input ready);
	modport sink(input valid, c_value, row, col, last, output ready);
endinterface

interface smm_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

/* sv/smm_mul.sv */
// smm_mul: one shared 32x32 multiplier, registered product
// depends on smm_pkg
`default_nettype none
module smm_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] x,
	input  wire logic [31:0] y,
	input  wire logic        en,
	output logic      [31:0] p_q
);
	// low half of product is all the wrap needs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
		end else if (en) begin
			p_q <= x * y;
		end
	end
endmodule
`default_nettype wire

/* sv/strassen_matrix_multiply_top.sv */
// strassen_matrix_multiply_top: loader, sequencer, stores and result stream
// depends on smm_pkg, smm_if, smm_mul
//
// Items (one A and one B element) load in row-major order, one per cycle
// while no config write is pending. After n*n items the C store is cleared.
// Then each of the (n/2)^3 block steps runs a fetch phase (eight operand
// reads through the registered store read ports), seven products through one
// shared multiplier and four read-modify-write accumulates. Results then
// stream out, one per accepted cycle. Input is not accepted while a job
// computes or emits. The order register is written only while the block waits
// for input; the user writes it only between requests, not enforced here.
`default_nettype none
module strassen_matrix_multiply_top #(
	parameter int MAX_ORDER = smm_pkg::MaxOrder,
	parameter int ELEM_BITS = smm_pkg::ElemBits
) (
	input wire logic clk,
	input wire logic arst_n,
	smm_in_if.sink   in_ch,
	smm_out_if.source out_ch,
	smm_cfg_if.sink  cfg
);
	localparam int Depth = MAX_ORDER * MAX_ORDER;
	localparam int AW = $clog2(Depth);
	localparam int CW = AW + 1;

	smm_pkg::state_t state_q, state_d;
	logic [1:0] lg_q;
	logic [CW-1:0] cnt_q;
	logic [2:0] bi_q, bj_q, bk_q;
	logic [3:0] step_q;
	logic phase_q;
	logic signed [ELEM_BITS-1:0] a_mem [Depth];
	logic signed [ELEM_BITS-1:0] b_mem [Depth];
	logic [31:0] c_mem [Depth];
	logic [31:0] a_op_q [4];
	logic [31:0] b_op_q [4];
	logic [31:0] p_q [7];
	logic [31:0] mx, my, prod;
	smm_pkg::mul_ctl_t mctl;

	// order and sizes
	logic [1:0] lg_eff;
	logic [3:0] n;
	logic [CW-1:0] total;
	always_comb begin
		lg_eff = (lg_q == 2'd0) ? 2'd1 : lg_q;
		if ((32'd1 << lg_eff) > MAX_ORDER) lg_eff = 2'($clog2(MAX_ORDER));
		n = 4'(4'd1 << lg_eff);
		total = CW'(32'd1 << (2 * lg_eff));
	end

	function automatic logic [AW-1:0] addr(input logic [2:0] r, input logic [2:0] c,
			input logic [1:0] l);
		logic [11:0] v;
		v = 12'(({9'd0, r} << l) + {9'd0, c});
		return v[AW-1:0];
	endfunction

	// operand read addresses for fetch step 0..7
	logic [2:0] fr, fc;
	always_comb begin
		if (step_q < 4'd4) begin
			fr = bi_q + 3'(step_q[1]);
			fc = bk_q + 3'(step_q[0]);
		end else begin
			fr = bk_q + 3'(step_q[1]);
			fc = bj_q + 3'(step_q[0]);
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= smm_pkg::ST_LOAD;
		else state_q <= state_d;
	end

	logic last_blk;
	assign last_blk = (4'(bk_q) + 4'd2 >= n) && (4'(bj_q) + 4'd2 >= n) &&
		(4'(bi_q) + 4'd2 >= n);
	logic out_fire, in_fire, cfg_fire;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign cfg_fire = cfg.valid && cfg.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			smm_pkg::ST_LOAD: if (in_fire && cnt_q + 1'b1 >= total) state_d = smm_pkg::ST_CLEAR;
			smm_pkg::ST_CLEAR: if (cnt_q + 1'b1 >= total) state_d = smm_pkg::ST_FETCH;
			smm_pkg::ST_FETCH: if (step_q == 4'd8) state_d = smm_pkg::ST_MUL;
			smm_pkg::ST_MUL: if (step_q == 4'd6 && phase_q) state_d = smm_pkg::ST_ACC;
			smm_pkg::ST_ACC: if (step_q == 4'd3 && phase_q)
				state_d = last_blk ? smm_pkg::ST_EMIT : smm_pkg::ST_FETCH;
			smm_pkg::ST_EMIT: if (out_fire && cnt_q + 1'b1 >= total) state_d = smm_pkg::ST_LOAD;
			default: state_d = smm_pkg::ST_LOAD;
		endcase
	end

	assign in_ch.ready = (state_q == smm_pkg::ST_LOAD) && !cfg.valid;
	assign cfg.ready = (state_q == smm_pkg::ST_LOAD);

	// multiplier operand select
	assign mctl.start = (state_q == smm_pkg::ST_MUL) && !phase_q;
	assign mctl.prod = step_q[2:0];
	always_comb begin
		case (mctl.prod)
			3'd0: begin mx = a_op_q[0] + a_op_q[3]; my = b_op_q[0] + b_op_q[3]; end
			3'd1: begin mx = a_op_q[2] + a_op_q[3]; my = b_op_q[0]; end
			3'd2: begin mx = a_op_q[0]; my = b_op_q[1] - b_op_q[3]; end
			3'd3: begin mx = a_op_q[3]; my = b_op_q[2] - b_op_q[0]; end
			3'd4: begin mx = a_op_q[0] + a_op_q[1]; my = b_op_q[3]; end
			3'd5: begin mx = a_op_q[2] - a_op_q[0]; my = b_op_q[0] + b_op_q[1]; end
			default: begin mx = a_op_q[1] - a_op_q[3]; my = b_op_q[2] + b_op_q[3]; end
		endcase
	end

	smm_mul u_mul (.clk(clk), .arst_n(arst_n), .x(mx), .y(my), .en(mctl.start), .p_q(prod));

	// element stores, one read per cycle
	logic signed [ELEM_BITS-1:0] a_in, b_in;
	assign a_in = ELEM_BITS'(in_ch.a_value);
	assign b_in = ELEM_BITS'(in_ch.b_value);
	logic [31:0] a_rd_q, b_rd_q;
	always_ff @(posedge clk) begin
		if (in_fire) begin
			a_mem[cnt_q[AW-1:0]] <= a_in;
			b_mem[cnt_q[AW-1:0]] <= b_in;
		end
		a_rd_q <= 32'(signed'(a_mem[addr(fr, fc, lg_eff)]));
		b_rd_q <= 32'(signed'(b_mem[addr(fr, fc, lg_eff)]));
	end

	// accumulate target and sum
	logic [AW-1:0] c_wa;
	logic [31:0] c_sum;
	always_comb begin
		c_wa = addr(bi_q + 3'(step_q[1]), bj_q + 3'(step_q[0]), lg_eff);
		case (step_q[1:0])
			2'd0: c_sum = p_q[0] + p_q[3] - p_q[4] + p_q[6];
			2'd1: c_sum = p_q[2] + p_q[4];
			2'd2: c_sum = p_q[1] + p_q[3];
			default: c_sum = p_q[0] + p_q[2] - p_q[1] + p_q[5];
		endcase
	end

	// C read address: emit walks ahead on accept, accumulate reads then writes,
	// write phase prefetches entry 0 for the emit that may follow
	logic [AW-1:0] c_ra;
	always_comb begin
		if (state_q == smm_pkg::ST_EMIT)
			c_ra = out_fire ? AW'(cnt_q + 1'b1) : cnt_q[AW-1:0];
		else if (state_q == smm_pkg::ST_ACC && phase_q)
			c_ra = '0;
		else
			c_ra = c_wa;
	end

	// C store: clear, read-modify-write, registered read
	logic [31:0] c_rd_q;
	always_ff @(posedge clk) begin
		if (state_q == smm_pkg::ST_CLEAR) c_mem[cnt_q[AW-1:0]] <= '0;
		else if (state_q == smm_pkg::ST_ACC && phase_q) c_mem[c_wa] <= c_rd_q + c_sum;
		c_rd_q <= c_mem[c_ra];
	end

	// counters and operand capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= 2'd3;
			cnt_q <= '0;
			step_q <= '0;
			phase_q <= 1'b0;
			bi_q <= '0; bj_q <= '0; bk_q <= '0;
			a_op_q <= '{default: '0};
			b_op_q <= '{default: '0};
			p_q <= '{default: '0};
		end else begin
			if (cfg_fire) begin
				lg_q <= cfg.data;
				cnt_q <= '0;
			end
			case (state_q)
				smm_pkg::ST_LOAD: if (in_fire) cnt_q <= (cnt_q + 1'b1 >= total) ? '0 : cnt_q + 1'b1;
				smm_pkg::ST_CLEAR: begin
					cnt_q <= (cnt_q + 1'b1 >= total) ? '0 : cnt_q + 1'b1;
					step_q <= '0;
					bi_q <= '0; bj_q <= '0; bk_q <= '0;
				end
				smm_pkg::ST_FETCH: begin
					if (step_q != 4'd0) begin
						if (step_q <= 4'd4) a_op_q[2'(step_q - 4'd1)] <= a_rd_q;
						else b_op_q[2'(step_q - 4'd5)] <= b_rd_q;
					end
					step_q <= (step_q == 4'd8) ? 4'd0 : step_q + 4'd1;
				end
				smm_pkg::ST_MUL: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						p_q[step_q[2:0]] <= prod;
						step_q <= (step_q == 4'd6) ? 4'd0 : step_q + 4'd1;
					end
				end
				smm_pkg::ST_ACC: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						step_q <= (step_q == 4'd3) ? 4'd0 : step_q + 4'd1;
						if (step_q == 4'd3) begin
							if (4'(bk_q) + 4'd2 < n) bk_q <= bk_q + 3'd2;
							else begin
								bk_q <= '0;
								if (4'(bj_q) + 4'd2 < n) bj_q <= bj_q + 3'd2;
								else begin bj_q <= '0; bi_q <= bi_q + 3'd2; end
							end
						end
					end
				end
				smm_pkg::ST_EMIT: if (out_fire) cnt_q <= (cnt_q + 1'b1 >= total) ? '0 : cnt_q + 1'b1;
				default: ;
			endcase
		end
	end

	// result channel
	assign out_ch.valid = (state_q == smm_pkg::ST_EMIT);
	assign out_ch.c_value = c_rd_q;
	assign out_ch.row = 3'(cnt_q >> lg_eff);
	assign out_ch.col = 3'(cnt_q) & 3'(n - 4'd1);
	assign out_ch.last = (cnt_q + 1'b1 == total);

	// checks
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != smm_pkg::ST_LOAD |-> !in_ch.ready) else $error("input taken while busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < total || cfg.valid || $past(cfg.valid)) else $error("count past job size");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && out_ch.last |=> state_q == smm_pkg::ST_LOAD) else $error("last not at end");
endmodule
`default_nettype wire
